// ----- hw/rtl/pc_sample_histogram_unit_defines.svh -----
// ---------------------------------------------------------------------------
// pc_sample_histogram_unit_defines.svh
// Assertion helper macros shared by the PC sample histogram RTL.
// ---------------------------------------------------------------------------
`ifndef PC_SAMPLE_HISTOGRAM_UNIT_DEFINES_SVH
`define PC_SAMPLE_HISTOGRAM_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PHS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PHS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/phs_pkg.sv -----
// ---------------------------------------------------------------------------
// phs_pkg
// Shared constants and types of the PC sample histogram unit.
// ---------------------------------------------------------------------------
package phs_pkg;

   localparam int BIN_COUNT = 1024;
   localparam int BIN_AW    = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;

   localparam int PC_W    = 32;
   localparam int SCALE_W = 17;
   localparam int BYTES_W = 12;
   localparam int TICK_W  = 8;
   localparam int RBIN_W  = 10;
   localparam int VAL_W   = 16;

   localparam int REQ_DW = 56;
   localparam int RSP_DW = 32;
   localparam int CSR_AW = 2;
   localparam int CSR_DW = 32;

   // Register indexes of the configuration port.
   localparam logic [CSR_AW-1:0] CSR_PC_OFFSET    = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_SAMPLE_SCALE = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_BUFFER_BYTES = 2'd2;

   // Scale of 1.0 in 16 fraction bits; larger writes are refused.
   localparam logic [SCALE_W-1:0] SCALE_ONE = 17'h10000;

   typedef struct packed {
      logic [PC_W-1:0]    pc_offset;
      logic [SCALE_W-1:0] sample_scale;
      logic [BYTES_W-1:0] buffer_bytes;
   } cfg_type;

   // One item leaving the index pipeline towards the bin store.
   typedef struct packed {
      logic              valid;
      logic              is_read;
      logic              hit;
      logic              rd_ok;
      logic [BIN_AW-1:0] addr;
      logic [RBIN_W-1:0] bin_number;
      logic [TICK_W-1:0] ticks;
   } lookup_type;

endpackage

// ----- hw/rtl/phs_csr.sv -----
// ---------------------------------------------------------------------------
// phs_csr
// Configuration registers: offset, scale and histogram size.
// ---------------------------------------------------------------------------
module phs_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [phs_pkg::CSR_AW-1:0] csr_addr,
   input  logic [phs_pkg::CSR_DW-1:0] csr_wdata,
   output phs_pkg::cfg_type           cfg
);
   import phs_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_addr)
            CSR_PC_OFFSET: begin
               cfg_in.pc_offset = csr_wdata[PC_W-1:0];
            end
            CSR_SAMPLE_SCALE: begin
               // Scales above 1.0 are ignored and the old value stays.
               if (csr_wdata[SCALE_W-1:0] <= SCALE_ONE) begin
                  cfg_in.sample_scale = csr_wdata[SCALE_W-1:0];
               end
            end
            CSR_BUFFER_BYTES: begin
               cfg_in.buffer_bytes = csr_wdata[BYTES_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

endmodule

// ----- hw/rtl/phs_index.sv -----
// ---------------------------------------------------------------------------
// phs_index
// Three-stage pipeline that turns a sample into a bin address.
// ---------------------------------------------------------------------------
module phs_index (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic                       take,
   input  logic                       func,
   input  logic [phs_pkg::PC_W-1:0]   sample_pc,
   input  logic [phs_pkg::TICK_W-1:0] tick_count,
   input  logic [phs_pkg::RBIN_W-1:0] read_bin,
   input  phs_pkg::cfg_type           cfg,
   output phs_pkg::lookup_type        lookup
);
   import phs_pkg::*;

   localparam int PROD_W = PC_W + SCALE_W;

   // Stage 1: input register.
   logic              v1_ff;
   logic              func1_ff;
   logic [PC_W-1:0]   pc1_ff;
   logic [TICK_W-1:0] ticks1_ff;
   logic [RBIN_W-1:0] rbin1_ff;

   // Stage 2: offset removed.
   logic              v2_ff;
   logic              func2_ff;
   logic              go2_ff;
   logic [PC_W-1:0]   diff2_ff;
   logic [TICK_W-1:0] ticks2_ff;
   logic [RBIN_W-1:0] rbin2_ff;

   // Stage 3: scaled byte index.
   logic              v3_ff;
   logic              func3_ff;
   logic              go3_ff;
   logic [PC_W-1:0]   idx3_ff;
   logic [TICK_W-1:0] ticks3_ff;
   logic [RBIN_W-1:0] rbin3_ff;

   logic [PC_W-1:0]   diff2_in;
   logic              go2_in;
   logic [PROD_W-1:0] prod;
   logic [PC_W-1:0]   idx3_in;
   logic              in_range;
   logic              in_store;
   logic              hit;

   assign diff2_in = pc1_ff - cfg.pc_offset;
   assign go2_in   = !func1_ff && (cfg.sample_scale != '0) && (ticks1_ff != '0)
                     && (pc1_ff >= cfg.pc_offset);

   assign prod    = PROD_W'(diff2_ff) * PROD_W'(cfg.sample_scale);
   // Shift right by 16 and clear bit 0, keeping the low word.
   assign idx3_in = {prod[PC_W+15:17], 1'b0};

   assign in_range = idx3_ff < PC_W'(cfg.buffer_bytes);
   assign in_store = idx3_ff[PC_W-1:1] < (PC_W-1)'(BIN_COUNT);
   assign hit      = go3_ff && in_range && in_store;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= take;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         func1_ff  <= func;
         pc1_ff    <= sample_pc;
         ticks1_ff <= tick_count;
         rbin1_ff  <= read_bin;

         func2_ff  <= func1_ff;
         go2_ff    <= go2_in;
         diff2_ff  <= diff2_in;
         ticks2_ff <= ticks1_ff;
         rbin2_ff  <= rbin1_ff;

         func3_ff  <= func2_ff;
         go3_ff    <= go2_ff;
         idx3_ff   <= idx3_in;
         ticks3_ff <= ticks2_ff;
         rbin3_ff  <= rbin2_ff;
      end
   end

   always_comb begin
      lookup.valid   = v3_ff;
      lookup.is_read = func3_ff;
      lookup.hit     = hit;
      lookup.rd_ok   = func3_ff && (PC_W'(rbin3_ff) < PC_W'(BIN_COUNT));
      lookup.ticks   = ticks3_ff;
      if (func3_ff) begin
         lookup.addr       = BIN_AW'(rbin3_ff);
         lookup.bin_number = rbin3_ff;
      end else begin
         lookup.addr       = idx3_ff[BIN_AW:1];
         lookup.bin_number = hit ? idx3_ff[RBIN_W:1] : '0;
      end
   end

endmodule

// ----- hw/rtl/phs_store.sv -----
// ---------------------------------------------------------------------------
// phs_store
// Bin memory with read-modify-write, write forwarding, clearing pass and
// the result register.
// ---------------------------------------------------------------------------
`include "pc_sample_histogram_unit_defines.svh"

module phs_store (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  phs_pkg::lookup_type        lookup,
   output logic                       clearing,
   output logic                       rsp_tvalid,
   output logic [phs_pkg::RSP_DW-1:0] rsp_tdata
);
   import phs_pkg::*;

   logic [VAL_W-1:0] hist_ff [BIN_COUNT];

   logic              clr_busy_ff;
   logic [BIN_AW-1:0] clr_addr_ff;

   // Stage 4: bin read back from memory.
   logic              v4_ff;
   logic              hit4_ff;
   logic              rdok4_ff;
   logic [BIN_AW-1:0] addr4_ff;
   logic [RBIN_W-1:0] num4_ff;
   logic [TICK_W-1:0] ticks4_ff;
   logic [VAL_W-1:0]  rd_data_ff;
   logic              byp_ff;
   logic [VAL_W-1:0]  byp_val_ff;

   // Result register.
   logic              rsp_valid_ff;
   logic              counted_ff;
   logic [RBIN_W-1:0] bin_number_ff;
   logic [VAL_W-1:0]  bin_value_ff;

   logic              rd_en;
   logic              upd_en;
   logic              wr_en;
   logic [BIN_AW-1:0] wr_addr;
   logic [VAL_W-1:0]  wr_data;
   logic [VAL_W-1:0]  cur4;
   logic [VAL_W-1:0]  sum4;
   logic [VAL_W-1:0]  bin_value_in;

   assign rd_en  = advance && lookup.valid && (lookup.hit || lookup.rd_ok);
   // An update written in the same cycle as the next read is forwarded.
   assign cur4   = byp_ff ? byp_val_ff : rd_data_ff;
   assign sum4   = cur4 + VAL_W'(ticks4_ff);
   assign upd_en = advance && v4_ff && hit4_ff;

   assign wr_en   = clr_busy_ff || upd_en;
   assign wr_addr = clr_busy_ff ? clr_addr_ff : addr4_ff;
   assign wr_data = clr_busy_ff ? '0 : sum4;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         hist_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= hist_ff[lookup.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         if (clr_addr_ff == BIN_AW'(BIN_COUNT - 1)) begin
            clr_busy_ff <= 1'b0;
         end
         clr_addr_ff <= clr_addr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff        <= 1'b0;
         byp_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         v4_ff        <= lookup.valid;
         byp_ff       <= rd_en && upd_en && (addr4_ff == lookup.addr);
         rsp_valid_ff <= v4_ff;
      end
   end

   always_comb begin
      if (hit4_ff) begin
         bin_value_in = sum4;
      end else if (rdok4_ff) begin
         bin_value_in = cur4;
      end else begin
         bin_value_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         hit4_ff    <= lookup.hit;
         rdok4_ff   <= lookup.rd_ok;
         addr4_ff   <= lookup.addr;
         num4_ff    <= lookup.bin_number;
         ticks4_ff  <= lookup.ticks;
         byp_val_ff <= sum4;

         counted_ff    <= hit4_ff;
         bin_number_ff <= num4_ff;
         bin_value_ff  <= bin_value_in;
      end
   end

   assign clearing   = clr_busy_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DW'({bin_value_ff, bin_number_ff, counted_ff});

   `PHS_ASSERT_NOW(a_clear_pipe_empty, clock, reset, clr_busy_ff,
                   !v4_ff && !lookup.valid, "item in flight during clearing pass")
   `PHS_ASSERT_NEXT(a_stall_keeps_bin, clock, reset,
                    !advance && v4_ff && (hit4_ff || rdok4_ff), $stable(cur4),
                    "bin value changed while stalled")
   `PHS_ASSERT_NOW(a_bypass_has_item, clock, reset, byp_ff, v4_ff,
                   "forwarded value without an item")

endmodule

// ----- hw/rtl/pc_sample_histogram_unit.sv -----
// ---------------------------------------------------------------------------
// pc_sample_histogram_unit
// Program-counter sampling histogram. A transfer on the req channel with
// tuser 0 adds tick_count to the bin selected by the scaled pc; with tuser 1
// it reads the bin given by read_bin. Every request gives exactly one
// transfer on the rsp channel, in request order.
// A request passes the input register, the offset stage, the scaled index
// stage with the range check, then the bin memory read and the update with
// forwarding, then the result register; one request is taken every cycle
// unless a result waits with rsp_tready low or the clearing pass runs.
// After reset a clearing pass writes zero to all 1024 bins, one per cycle;
// req_tready stays low until the pass is done. Configuration writes are
// taken at any time and must be made while no request is in flight.
// When a result waits with rsp_tready low the whole pipeline holds and
// req_tready is low in the same cycle, so no result is lost.
// ---------------------------------------------------------------------------
`include "pc_sample_histogram_unit_defines.svh"

module pc_sample_histogram_unit (
   input  logic                       clock,
   input  logic                       reset,
   // req_tdata: sample_pc[31:0], tick_count[39:32], read_bin[49:40], zero.
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [phs_pkg::REQ_DW-1:0] req_tdata,
   // req_tuser: func (0 add sample, 1 read bin).
   input  logic [0:0]                 req_tuser,
   // rsp_tdata: counted[0], bin_number[10:1], bin_value[26:11], zero.
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [phs_pkg::RSP_DW-1:0] rsp_tdata,
   // Register index 0 pc_offset, 1 sample_scale, 2 buffer_bytes.
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [phs_pkg::CSR_AW-1:0] csr_addr,
   input  logic [phs_pkg::CSR_DW-1:0] csr_wdata
);
   import phs_pkg::*;

   cfg_type    cfg;
   lookup_type lookup;
   logic       advance;
   logic       clearing;
   logic       take;

   // The pipeline moves whenever the result register is empty or drained.
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance && !clearing;
   assign take       = req_tvalid && req_tready;

   phs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   phs_index u_index (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .take       (take),
      .func       (req_tuser[0]),
      .sample_pc  (req_tdata[PC_W-1:0]),
      .tick_count (req_tdata[PC_W+TICK_W-1:PC_W]),
      .read_bin   (req_tdata[PC_W+TICK_W+RBIN_W-1:PC_W+TICK_W]),
      .cfg        (cfg),
      .lookup     (lookup)
   );

   phs_store u_store (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .lookup     (lookup),
      .clearing   (clearing),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

   `PHS_ASSERT_NOW(a_no_take_while_clearing, clock, reset, clearing, !req_tready,
                   "request taken during clearing pass")
   `PHS_ASSERT_NEXT(a_stall_blocks_input, clock, reset, rsp_tvalid && !rsp_tready,
                    !$past(req_tready), "request taken while result stalled")
   `PHS_ASSERT_NOW(a_scale_in_range, clock, reset, 1'b1, cfg.sample_scale <= SCALE_ONE,
                   "scale register above one")

endmodule

// ----- verif/phs_tb_pkg.sv -----
// ---------------------------------------------------------------------------
// phs_tb_pkg
// Codes shared by the verification modules of the PC sample histogram unit.
// ---------------------------------------------------------------------------
package phs_tb_pkg;

   // Meaning of req_tuser.
   typedef enum logic [0:0] {
      FUNC_ADD_SAMPLE = 1'b0,
      FUNC_READ_BIN   = 1'b1
   } req_func_type;

   // A register index that maps to no register.
   localparam logic [phs_pkg::CSR_AW-1:0] CSR_SPARE = 2'd3;

   // Fraction bits of sample_scale.
   localparam int FRAC_W = 16;

endpackage

// ----- verif/phs_checker.sv -----
// ---------------------------------------------------------------------------
// phs_checker
// Watches the request, response and register channels of the histogram
// unit, keeps its own copy of the bins and settings, and compares every
// response transfer with the oldest outstanding prediction.
// ---------------------------------------------------------------------------
module phs_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   input  logic                       req_tready,
   input  logic [phs_pkg::REQ_DW-1:0] req_tdata,
   input  logic [0:0]                 req_tuser,
   input  logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic [phs_pkg::RSP_DW-1:0] rsp_tdata,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [phs_pkg::CSR_AW-1:0] csr_addr,
   input  logic [phs_pkg::CSR_DW-1:0] csr_wdata,
   output int                         fault_total,
   output int                         in_flight
);
   timeunit 1ns;
   timeprecision 1ps;

   import phs_pkg::*;
   import phs_tb_pkg::*;

   typedef struct packed {
      logic              counted;
      logic [RBIN_W-1:0] bin_number;
      logic [VAL_W-1:0]  bin_value;
   } bin_report_type;

   logic [PC_W-1:0]    offset_q;
   logic [SCALE_W-1:0] scale_q;
   logic [BYTES_W-1:0] bytes_q;
   logic [VAL_W-1:0]   bin_counts [BIN_COUNT];
   bin_report_type     due_reports [$];

   task automatic flag_fault(input string what);
      $display("[%0t] histogram check: %s", $time, what);
      fault_total++;
   endtask

   // Applies one request to the bin copy and returns the response it causes.
   function automatic bin_report_type tally(input req_func_type func,
                                            input logic [PC_W-1:0] pc,
                                            input logic [TICK_W-1:0] ticks,
                                            input logic [RBIN_W-1:0] rbin);
      bin_report_type          r;
      logic [PC_W+SCALE_W-1:0] wide_dist;
      logic [PC_W+SCALE_W-1:0] product;
      logic [PC_W-1:0]         byte_idx;
      logic [BIN_AW-1:0]       slot;
      r = '0;
      if (func == FUNC_READ_BIN) begin
         r.bin_number = rbin;
         r.bin_value  = bin_counts[rbin];
      end else if (scale_q != 0 && ticks != 0 && pc >= offset_q) begin
         wide_dist = (PC_W+SCALE_W)'(pc - offset_q);
         product   = wide_dist * (PC_W+SCALE_W)'(scale_q);
         byte_idx  = product[PC_W+FRAC_W-1:FRAC_W] & ~32'd1;
         if (byte_idx < PC_W'(bytes_q) && (byte_idx >> 1) < BIN_COUNT) begin
            slot             = byte_idx[BIN_AW:1];
            bin_counts[slot] = bin_counts[slot] + VAL_W'(ticks);
            r.counted        = 1'b1;
            r.bin_number     = RBIN_W'(slot);
            r.bin_value      = bin_counts[slot];
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      bin_report_type got;
      bin_report_type want;
      if (reset) begin
         offset_q = '0;
         scale_q  = '0;
         bytes_q  = '0;
         foreach (bin_counts[i]) bin_counts[i] = '0;
         due_reports.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_addr)
               CSR_PC_OFFSET: offset_q = csr_wdata[PC_W-1:0];
               CSR_SAMPLE_SCALE: begin
                  if (csr_wdata[SCALE_W-1:0] <= SCALE_ONE) scale_q = csr_wdata[SCALE_W-1:0];
               end
               CSR_BUFFER_BYTES: bytes_q = csr_wdata[BYTES_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got.counted    = rsp_tdata[0];
            got.bin_number = rsp_tdata[RBIN_W:1];
            got.bin_value  = rsp_tdata[RBIN_W+VAL_W:RBIN_W+1];
            if (due_reports.size() == 0) begin
               flag_fault($sformatf("unexpected response %h", rsp_tdata));
            end else begin
               want = due_reports.pop_front();
               if (got.counted !== want.counted)
                  flag_fault($sformatf("counted %b, wanted %b", got.counted, want.counted));
               if (got.bin_number !== want.bin_number)
                  flag_fault($sformatf("bin_number %0d, wanted %0d",
                                       got.bin_number, want.bin_number));
               if (got.bin_value !== want.bin_value)
                  flag_fault($sformatf("bin_value %0d, wanted %0d",
                                       got.bin_value, want.bin_value));
            end
         end
         if (req_tvalid && req_tready)
            due_reports.push_back(tally(req_func_type'(req_tuser),
                                        req_tdata[PC_W-1:0],
                                        req_tdata[PC_W+TICK_W-1:PC_W],
                                        req_tdata[PC_W+TICK_W+RBIN_W-1:PC_W+TICK_W]));
      end
      in_flight = due_reports.size();
   end

endmodule

// ----- verif/tb_top.sv -----
// ---------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the PC sample histogram unit. A directed pass
// covers the range edges, disabled profiling, rejected scale writes and the
// spare register index; random phases then run under varied settings with
// bursts of idling on both streams. The checker beside the block predicts
// and compares every response transfer.
// ---------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import phs_pkg::*;
   import phs_tb_pkg::*;

   // The limit leaves ample margin over the slowest legal run, including
   // the clearing pass after reset.
   localparam int CYCLE_LIMIT = 400000;
   // The pipeline is five stages deep; the tail waits beyond that to catch stray results.
   localparam int TAIL_CYCLES = 16;
   localparam int REQ_PAD     = REQ_DW - PC_W - TICK_W - RBIN_W;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_DW-1:0] req_tdata  = '0;
   logic [0:0]        req_tuser  = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_DW-1:0] rsp_tdata;
   logic              csr_valid  = 1'b0;
   logic              csr_ready;
   logic [CSR_AW-1:0] csr_addr   = '0;
   logic [CSR_DW-1:0] csr_wdata  = '0;

   int fault_total;
   int in_flight;
   int cycle_count = 0;
   int stall_left  = 0;
   bit idle_on     = 1'b1;

   // The settings the block currently holds, used only to aim the stimulus.
   logic [PC_W-1:0]    cur_offset = '0;
   logic [SCALE_W-1:0] cur_scale  = '0;
   logic [BYTES_W-1:0] cur_bytes  = '0;

   always #2 clock = ~clock;

   pc_sample_histogram_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   phs_checker histogram_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .fault_total (fault_total),
      .in_flight   (in_flight)
   );

   // Watchdog: a run that hangs anywhere ends here as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Receiver side. While idling is enabled, rsp_tready drops low in bursts
   // of random length; otherwise every response transfer is taken at
   // once. The level only ever changes at the falling edge.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left <= int'($urandom_range(0, 14));
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // One register write. The write is a transfer at the first rising edge
   // with csr_ready high; the valid is lowered at the next falling edge.
   task automatic write_reg(input logic [CSR_AW-1:0] idx, input logic [CSR_DW-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Stops the request stream and waits, at falling edges where the checker's
   // count is settled, until every outstanding response has arrived. Every
   // request causes exactly one response, so the block is then idle.
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (in_flight != 0) @(negedge clock);
   endtask

   task automatic apply_setup(input logic [PC_W-1:0] offset,
                              input logic [SCALE_W-1:0] scale,
                              input logic [BYTES_W-1:0] bytes);
      settle();
      write_reg(CSR_PC_OFFSET, offset);
      write_reg(CSR_SAMPLE_SCALE, CSR_DW'(scale));
      write_reg(CSR_BUFFER_BYTES, CSR_DW'(bytes));
      cur_offset = offset;
      if (scale <= SCALE_ONE) cur_scale = scale;
      cur_bytes = bytes;
   endtask

   // Offers one request and returns at the rising edge of its transfer.
   // A gap of idle cycles may precede it while idling is on.
   task automatic send_req(input req_func_type func, input logic [PC_W-1:0] pc,
                           input logic [TICK_W-1:0] ticks, input logic [RBIN_W-1:0] rbin);
      int gap;
      @(negedge clock);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         gap = int'($urandom_range(1, 15));
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {{REQ_PAD{1'b0}}, rbin, ticks, pc};
      do @(posedge clock); while (!req_tready);
   endtask

   // Random traffic aimed at the current settings. Most samples fall inside
   // the profiled window, slightly past its top as well, so that bins are
   // really updated; the rest lie below the offset or anywhere at all.
   // Reads favour the bins that the window can reach. With heavy set the
   // tick counts are large so that a small histogram wraps.
   task automatic random_traffic(input int count, input bit heavy);
      int                roll;
      logic [PC_W-1:0]   pc;
      logic [TICK_W-1:0] ticks;
      logic [RBIN_W-1:0] rbin;
      longint unsigned   span;
      int unsigned       hot;
      for (int n = 0; n < count; n++) begin
         roll = int'($urandom_range(0, 99));
         pc   = $urandom;
         rbin = RBIN_W'($urandom);
         if (roll < 20) begin
            hot = 32'(cur_bytes >> 1);
            if (hot > 1023) hot = 1023;
            if (roll < 10) rbin = RBIN_W'($urandom_range(0, hot));
            send_req(FUNC_READ_BIN, pc, TICK_W'($urandom), rbin);
         end else begin
            if (roll < 80 && cur_scale != 0) begin
               span = 64'(cur_bytes);
               span = (span << FRAC_W) / 64'(cur_scale) + 64'd4;
               if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
               pc = cur_offset + $urandom_range(0, 32'(span));
            end else if (roll < 90 && cur_offset != 0) begin
               pc = $urandom_range(0, cur_offset - 1);
            end
            if (heavy) ticks = TICK_W'($urandom_range(200, 255));
            else if ($urandom_range(0, 9) == 0) ticks = 0;
            else ticks = TICK_W'($urandom_range(1, 255));
            send_req(FUNC_ADD_SAMPLE, pc, ticks, rbin);
         end
      end
   endtask

   initial begin
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // Directed part. Profiling is off straight after reset, so the first
      // sample must not count, and the cleared store reads as zero.
      send_req(FUNC_ADD_SAMPLE, 32'h0000_1234, 8'd7, '0);
      send_req(FUNC_READ_BIN, '0, '0, 10'd0);

      // Unit scale over a 2048-byte buffer: both ends of the window, the
      // first address past it, an address below the offset and zero ticks.
      apply_setup(32'h0000_1000, SCALE_ONE, 12'd2048);
      send_req(FUNC_ADD_SAMPLE, 32'h0000_1000, 8'd1, '0);
      send_req(FUNC_ADD_SAMPLE, 32'h0000_1001, 8'd255, '0);
      send_req(FUNC_ADD_SAMPLE, 32'h0000_17FF, 8'd255, '0);
      send_req(FUNC_ADD_SAMPLE, 32'h0000_1800, 8'd4, '0);
      send_req(FUNC_ADD_SAMPLE, 32'h0000_0FFF, 8'd3, '0);
      send_req(FUNC_ADD_SAMPLE, 32'h0000_1010, 8'd0, '0);
      send_req(FUNC_READ_BIN, '0, '0, 10'd0);
      send_req(FUNC_READ_BIN, '0, '0, 10'd1023);
      send_req(FUNC_READ_BIN, '0, '0, 10'h2AA);
      send_req(FUNC_READ_BIN, '0, '0, 10'h155);

      // Scale writes above one are refused and the spare index does nothing,
      // so the next sample must still use unit scale.
      settle();
      write_reg(CSR_SAMPLE_SCALE, 32'h0001_0001);
      write_reg(CSR_SAMPLE_SCALE, 32'h0001_FFFF);
      write_reg(CSR_SPARE, 32'hFFFF_FFFF);
      send_req(FUNC_ADD_SAMPLE, 32'h0000_1010, 8'd9, '0);

      // A buffer larger than the store: indices past the last bin are
      // dropped, the last bin itself still counts.
      settle();
      write_reg(CSR_BUFFER_BYTES, 32'h0000_0FFF);
      cur_bytes = 12'hFFF;
      send_req(FUNC_ADD_SAMPLE, 32'h0000_1000 + 32'd3000, 8'd4, '0);
      send_req(FUNC_ADD_SAMPLE, 32'h0000_1000 + 32'd2046, 8'd4, '0);

      // Highest offset with the smallest scale: only the top address counts.
      apply_setup(32'hFFFF_FFFF, 17'd1, 12'd2048);
      send_req(FUNC_ADD_SAMPLE, 32'hFFFF_FFFF, 8'd2, '0);
      send_req(FUNC_ADD_SAMPLE, 32'hFFFF_FFFE, 8'd2, '0);

      // An empty buffer drops everything; then the widest product.
      apply_setup('0, SCALE_ONE, 12'd0);
      send_req(FUNC_ADD_SAMPLE, 32'h0000_0000, 8'd5, '0);
      apply_setup('0, SCALE_ONE, 12'd2048);
      send_req(FUNC_ADD_SAMPLE, 32'hFFFF_FFFF, 8'd1, 10'h3FF);
      send_req(FUNC_ADD_SAMPLE, 32'h0000_07FF, 8'hAA, 10'h2AA);
      send_req(FUNC_ADD_SAMPLE, 32'h0000_0555, 8'h55, 10'h155);
      send_req(FUNC_READ_BIN, 32'hFFFF_FFFF, 8'hFF, 10'd1023);

      // Random phases under different settings. Phase three runs without
      // idling in mid-run, phase four wraps a one-bin histogram, and the
      // final phase runs with both streams at full rate.
      for (int ph = 0; ph < 9; ph++) begin
         settle();
         idle_on = (ph != 3) && (ph != 8);
         case (ph)
            0: begin
               apply_setup($urandom_range(0, 32'h8000_0000), SCALE_ONE, 12'd2048);
               random_traffic(200, 1'b0);
            end
            1: begin
               apply_setup('0, SCALE_W'($urandom_range(1, SCALE_ONE)),
                           BYTES_W'($urandom_range(1, 2048)));
               random_traffic(200, 1'b0);
            end
            2: begin
               apply_setup($urandom, 17'h08000, 12'd1024);
               write_reg(CSR_SAMPLE_SCALE, $urandom_range(SCALE_ONE + 1, 32'h1_FFFF));
               random_traffic(200, 1'b0);
            end
            3: begin
               apply_setup('0, 17'd1, 12'd2048);
               random_traffic(200, 1'b0);
            end
            4: begin
               apply_setup($urandom_range(0, 32'h0010_0000), SCALE_ONE, 12'd2);
               random_traffic(300, 1'b1);
            end
            5: begin
               apply_setup($urandom, SCALE_W'($urandom_range(1, SCALE_ONE)), 12'hFFF);
               random_traffic(200, 1'b0);
            end
            6: begin
               apply_setup($urandom, SCALE_ONE, 12'd0);
               random_traffic(80, 1'b0);
            end
            7: begin
               apply_setup('0, '0, 12'd2048);
               random_traffic(80, 1'b0);
            end
            default: begin
               apply_setup($urandom_range(0, 32'h4000_0000),
                           SCALE_W'($urandom_range(1, SCALE_ONE)),
                           BYTES_W'($urandom_range(2, 2048)));
               random_traffic(200, 1'b0);
            end
         endcase
      end

      // Drain, then give any stray response time to show up.
      settle();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (fault_total == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
